/* rtl/enhf_pkg.sv */
// ----------------------------------------------------------------------------
// enhf_pkg: ECG notch / high-pass / FIR chain definitions
// Widths, coefficient tables and the sequencer microprogram.
// ----------------------------------------------------------------------------
package enhf_pkg;

   localparam int SAMPLE_W  = 24;   // raw sample port width
   localparam int X0_W      = 20;   // notch input, sample >>> 4
   localparam int WIDE_W    = 32;   // notch output / DC blocker state
   localparam int TAP_W     = 16;   // FIR delay line word
   localparam int OUT_W     = 21;   // filtered result
   localparam int COEF_W    = 11;   // signed coefficient width
   localparam int PRE_W     = TAP_W + 1;
   localparam int ACC_W     = 40;   // modular accumulator, covers every extracted bit
   localparam int PROD_W    = COEF_W + WIDE_W;
   localparam int Y_LSB     = 8;    // all stages scale by >>> 8

   localparam int TAP_COUNT = 51;
   localparam int HALF_TAPS = (TAP_COUNT + 1) / 2;
   localparam int CENTER    = HALF_TAPS - 1;
   localparam int PTR_W     = $clog2(TAP_COUNT);
   localparam int K_W       = $clog2(HALF_TAPS + 1);
   localparam int KIDX_W    = $clog2(HALF_TAPS);

   localparam int STEPS     = 16;
   localparam int PC_W      = $clog2(STEPS);

   // low-pass half table, outermost tap first, center tap last
   localparam logic signed [COEF_W-1:0] LP_COEF [HALF_TAPS] = '{
      -11'sd4,  -11'sd4,  -11'sd3,  -11'sd2,   11'sd2,   11'sd6,   11'sd12,
       11'sd18,  11'sd21,  11'sd19,  11'sd11, -11'sd5,  -11'sd27, -11'sd52,
      -11'sd74, -11'sd85, -11'sd78, -11'sd47,  11'sd10,  11'sd92,  11'sd193,
       11'sd302, 11'sd408, 11'sd496, 11'sd554, 11'sd574
   };

   typedef enum logic [2:0] {
      SRC_X0,
      SRC_NIN0,
      SRC_NIN1,
      SRC_NOUT0,
      SRC_NOUT1,
      SRC_DC_OUT,
      SRC_TAPS
   } src_type;

   typedef enum logic [1:0] {
      COND_NONE,   // fall through to next step
      COND_REQ,    // hold until an input transfer
      COND_LOOP,   // repeat until last FIR pair issued
      COND_OUT     // hold until the result register is free
   } cond_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LOAD,    // capture sample
      ACT_NOTCH,   // retire notch output, shift notch history
      ACT_HP,      // DC blocker output, write delay line
      ACT_FIR,     // walk the delay line pointers
      ACT_EMIT     // load result register
   } act_type;

   typedef struct packed {
      logic                mac;
      logic                first;
      src_type             src;
      logic [COEF_W-1:0]   coef;
      cond_type            cond;
      act_type             act;
      logic [PC_W-1:0]     target;
   } uword_type;

   localparam logic [PC_W-1:0] STEP_IDLE  = PC_W'(0);
   localparam logic [PC_W-1:0] STEP_NOTCH = PC_W'(1);
   localparam logic [PC_W-1:0] STEP_DRAIN = PC_W'(13);

   function automatic uword_type mk_uw(logic mac, logic first, src_type src,
                                       logic signed [COEF_W-1:0] coef,
                                       cond_type cond, act_type act,
                                       logic [PC_W-1:0] target);
      uword_type w;
      w.mac    = mac;
      w.first  = first;
      w.src    = src;
      w.coef   = coef;
      w.cond   = cond;
      w.act    = act;
      w.target = target;
      return w;
   endfunction

   // MAC results pass the operand, product and accumulator registers before they can be read, hence the empty steps.
   localparam uword_type UCODE [STEPS] = '{
      mk_uw(1'b0, 1'b0, SRC_X0,     11'sd0,   COND_REQ,  ACT_LOAD,  STEP_NOTCH),
      mk_uw(1'b1, 1'b1, SRC_X0,     11'sd223, COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b1, 1'b0, SRC_NIN0,  -11'sd361, COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b1, 1'b0, SRC_NIN1,   11'sd223, COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b1, 1'b0, SRC_NOUT0,  11'sd361, COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b1, 1'b0, SRC_NOUT1, -11'sd190, COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b0, 1'b0, SRC_X0,     11'sd0,   COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b0, 1'b0, SRC_X0,     11'sd0,   COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b1, 1'b1, SRC_DC_OUT, 11'sd254, COND_NONE, ACT_NOTCH, STEP_IDLE),
      mk_uw(1'b0, 1'b0, SRC_X0,     11'sd0,   COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b0, 1'b0, SRC_X0,     11'sd0,   COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b0, 1'b0, SRC_X0,     11'sd0,   COND_NONE, ACT_HP,    STEP_IDLE),
      mk_uw(1'b1, 1'b0, SRC_TAPS,   11'sd0,   COND_LOOP, ACT_FIR,   STEP_DRAIN),
      mk_uw(1'b0, 1'b0, SRC_X0,     11'sd0,   COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b0, 1'b0, SRC_X0,     11'sd0,   COND_NONE, ACT_NONE,  STEP_IDLE),
      mk_uw(1'b0, 1'b0, SRC_X0,     11'sd0,   COND_OUT,  ACT_EMIT,  STEP_IDLE)
   };

endpackage

/* rtl/ecg_notch_highpass_fir_chain.sv */
// ----------------------------------------------------------------------------
// ecg_notch_highpass_fir_chain: three-stage ECG filter
// Notch biquad, DC blocker and 51-tap symmetric low-pass FIR on one shared MAC.
// ----------------------------------------------------------------------------
// One signed sample in per req_ transfer, one filtered sample out per rsp_
// transfer, in order. Stage 1 is a Q8 notch biquad on the sample shifted
// right by 4; stage 2 a DC blocker with alpha 254/256; stage 3 a 51-tap
// symmetric Q12 FIR fed with the DC blocker output wrapped to 16 bits, its
// sum shifted right by 8. All shifts floor. Every filter store starts at zero
// after reset. A 16-step microprogram drives one multiplier and one
// accumulator, and the FIR step loops over the 26 half-table coefficients,
// one coefficient pair per cycle off a two-read-port delay line memory. The
// next sample can be taken in the cycle after the result is loaded, even
// while that result still waits for rsp_ready; on the output side the
// sequencer only stalls if a second result is ready before the first left.
// Bits of req_sample_in above SAMPLE_BITS are ignored (sign taken from bit
// SAMPLE_BITS-1).
module ecg_notch_highpass_fir_chain #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [enhf_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [enhf_pkg::OUT_W-1:0]    rsp_filtered_out
);

   localparam int PAD = enhf_pkg::SAMPLE_W - SAMPLE_BITS;
   localparam logic [enhf_pkg::PTR_W-1:0] LAST_PTR = enhf_pkg::PTR_W'(enhf_pkg::TAP_COUNT - 1);

   // ---- sequencer ----
   logic [enhf_pkg::PC_W-1:0]   pc_ff, pc_in;
   enhf_pkg::uword_type         uw;
   logic                        cond_met;

   // ---- filter state ----
   logic [enhf_pkg::X0_W-1:0]   x0_ff, x0_in;
   logic [enhf_pkg::X0_W-1:0]   nin0_ff, nin0_in, nin1_ff, nin1_in;
   logic [enhf_pkg::WIDE_W-1:0] nout0_ff, nout0_in, nout1_ff, nout1_in;
   logic [enhf_pkg::WIDE_W-1:0] dc_in_ff, dc_in_in, dc_out_ff, dc_out_in;
   logic [enhf_pkg::WIDE_W-1:0] y0_ff, y0_in;
   logic [enhf_pkg::WIDE_W-1:0] hp;
   logic [enhf_pkg::PTR_W-1:0]  head_ff, head_in;
   logic [enhf_pkg::K_W-1:0]    k_ff, k_in;
   logic [enhf_pkg::PTR_W-1:0]  ptr_a_ff, ptr_a_in, ptr_b_ff, ptr_b_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [enhf_pkg::OUT_W-1:0]  rsp_data_ff, rsp_data_in;

   // ---- delay line ----
   logic [enhf_pkg::TAP_W-1:0]  tap_mem [enhf_pkg::TAP_COUNT];
   logic [enhf_pkg::TAP_COUNT-1:0] tap_vld_ff;
   logic                        tap_wr;

   // ---- MAC pipeline: operand, multiply, accumulate ----
   logic                        issue, issue_first, issue_taps;
   logic signed [enhf_pkg::COEF_W-1:0] issue_coef;
   logic [enhf_pkg::WIDE_W-1:0] issue_opnd;
   logic                        s1_vld_ff, s1_first_ff, s1_taps_ff, s1_center_ff;
   logic signed [enhf_pkg::COEF_W-1:0] s1_coef_ff;
   logic [enhf_pkg::WIDE_W-1:0] s1_opnd_ff;
   logic [enhf_pkg::TAP_W-1:0]  rd_a_ff, rd_b_ff;
   logic signed [enhf_pkg::PRE_W-1:0]  pre_sum;
   logic signed [enhf_pkg::WIDE_W-1:0] mul_b;
   logic signed [enhf_pkg::PROD_W-1:0] prod_full;
   logic                        s2_vld_ff, s2_first_ff;
   logic [enhf_pkg::ACC_W-1:0]  prod_ff;
   logic [enhf_pkg::ACC_W-1:0]  acc_ff;

   logic [enhf_pkg::SAMPLE_W-1:0] samp_shl;
   logic signed [enhf_pkg::SAMPLE_W-1:0] samp;

   assign uw        = enhf_pkg::UCODE[pc_ff];
   assign req_ready = (uw.cond == enhf_pkg::COND_REQ);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered_out = rsp_data_ff;

   // sign-extend from SAMPLE_BITS
   assign samp_shl = req_sample_in << PAD;
   assign samp     = $signed(samp_shl) >>> PAD;

   // DC blocker: y0 - prev_in + floor(254*prev_out / 256); acc holds 254*prev_out
   assign hp = y0_ff - dc_in_ff + acc_ff[enhf_pkg::ACC_W-1 -: enhf_pkg::WIDE_W];

   always_comb begin
      case (uw.cond)
         enhf_pkg::COND_REQ:  cond_met = req_valid;
         enhf_pkg::COND_LOOP: cond_met = (k_ff == enhf_pkg::K_W'(enhf_pkg::CENTER));
         enhf_pkg::COND_OUT:  cond_met = !rsp_valid_ff || rsp_ready;
         default:             cond_met = 1'b1;
      endcase
   end

   // operand selection for the multiply
   always_comb begin
      case (uw.src)
         enhf_pkg::SRC_X0:     issue_opnd = enhf_pkg::WIDE_W'($signed(x0_ff));
         enhf_pkg::SRC_NIN0:   issue_opnd = enhf_pkg::WIDE_W'($signed(nin0_ff));
         enhf_pkg::SRC_NIN1:   issue_opnd = enhf_pkg::WIDE_W'($signed(nin1_ff));
         enhf_pkg::SRC_NOUT0:  issue_opnd = nout0_ff;
         enhf_pkg::SRC_NOUT1:  issue_opnd = nout1_ff;
         enhf_pkg::SRC_DC_OUT: issue_opnd = dc_out_ff;
         default:              issue_opnd = '0;
      endcase
   end

   assign issue       = uw.mac;
   assign issue_taps  = (uw.src == enhf_pkg::SRC_TAPS);
   assign issue_first = uw.first || (issue_taps && (k_ff == '0));
   assign issue_coef  = issue_taps ? enhf_pkg::LP_COEF[k_ff[enhf_pkg::KIDX_W-1:0]]
                                   : $signed(uw.coef);
   assign tap_wr      = (uw.act == enhf_pkg::ACT_HP);

   // sequencer next state and datapath register updates
   always_comb begin
      pc_in        = pc_ff;
      x0_in        = x0_ff;
      nin0_in      = nin0_ff;
      nin1_in      = nin1_ff;
      nout0_in     = nout0_ff;
      nout1_in     = nout1_ff;
      dc_in_in     = dc_in_ff;
      dc_out_in    = dc_out_ff;
      y0_in        = y0_ff;
      head_in      = head_ff;
      k_in         = k_ff;
      ptr_a_in     = ptr_a_ff;
      ptr_b_in     = ptr_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (uw.cond == enhf_pkg::COND_NONE) begin
         pc_in = pc_ff + 1'b1;
      end else if (cond_met) begin
         pc_in = uw.target;
      end

      unique case (uw.act)
         enhf_pkg::ACT_LOAD: begin
            if (cond_met) begin
               x0_in = samp[enhf_pkg::SAMPLE_W-1 -: enhf_pkg::X0_W];  // floor >>> 4
            end
         end
         enhf_pkg::ACT_NOTCH: begin
            y0_in    = acc_ff[enhf_pkg::ACC_W-1 -: enhf_pkg::WIDE_W];
            nin1_in  = nin0_ff;
            nin0_in  = x0_ff;
            nout1_in = nout0_ff;
            nout0_in = acc_ff[enhf_pkg::ACC_W-1 -: enhf_pkg::WIDE_W];
         end
         enhf_pkg::ACT_HP: begin
            dc_in_in  = y0_ff;
            dc_out_in = hp;
            // pair walk: a goes back from head, b forward from head+1
            k_in      = '0;
            ptr_a_in  = head_ff;
            ptr_b_in  = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
            head_in   = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
         end
         enhf_pkg::ACT_FIR: begin
            k_in     = k_ff + 1'b1;
            ptr_a_in = (ptr_a_ff == '0) ? LAST_PTR : ptr_a_ff - 1'b1;
            ptr_b_in = (ptr_b_ff == LAST_PTR) ? '0 : ptr_b_ff + 1'b1;
         end
         enhf_pkg::ACT_EMIT: begin
            if (cond_met) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff[enhf_pkg::Y_LSB + enhf_pkg::OUT_W - 1 : enhf_pkg::Y_LSB];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= enhf_pkg::STEP_IDLE;
         nin0_ff      <= '0;
         nin1_ff      <= '0;
         nout0_ff     <= '0;
         nout1_ff     <= '0;
         dc_in_ff     <= '0;
         dc_out_ff    <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         nin0_ff      <= nin0_in;
         nin1_ff      <= nin1_in;
         nout0_ff     <= nout0_in;
         nout1_ff     <= nout1_in;
         dc_in_ff     <= dc_in_in;
         dc_out_ff    <= dc_out_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      k_ff        <= k_in;
      ptr_a_ff    <= ptr_a_in;
      ptr_b_ff    <= ptr_b_in;
      rsp_data_ff <= rsp_data_in;
   end

   // delay line: one write, two registered reads; unwritten entries read zero
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff <= '0;
      end else if (tap_wr) begin
         tap_vld_ff[head_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tap_wr) begin
         tap_mem[head_ff] <= hp[enhf_pkg::TAP_W-1:0];
      end
      rd_a_ff <= tap_vld_ff[ptr_a_ff] ? tap_mem[ptr_a_ff] : '0;
      rd_b_ff <= tap_vld_ff[ptr_b_ff] ? tap_mem[ptr_b_ff] : '0;
   end

   // multiply stage: symmetric pre-add for FIR pairs, center tap alone
   assign pre_sum = enhf_pkg::PRE_W'($signed(rd_a_ff))
                  + (s1_center_ff ? '0 : enhf_pkg::PRE_W'($signed(rd_b_ff)));
   assign mul_b     = s1_taps_ff ? enhf_pkg::WIDE_W'(pre_sum) : $signed(s1_opnd_ff);
   assign prod_full = enhf_pkg::PROD_W'(s1_coef_ff) * enhf_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
      s1_first_ff  <= issue_first;
      s1_taps_ff   <= issue_taps;
      s1_center_ff <= (k_ff == enhf_pkg::K_W'(enhf_pkg::CENTER));
      s1_coef_ff   <= issue_coef;
      s1_opnd_ff   <= issue_opnd;
      s2_first_ff  <= s1_first_ff;
      prod_ff      <= prod_full[enhf_pkg::ACC_W-1:0];
      // accumulate modulo 2^ACC_W; no bit above ACC_W-1 is ever extracted
      if (s2_vld_ff) begin
         acc_ff <= (s2_first_ff ? '0 : acc_ff) + prod_ff;
      end
   end

endmodule
